@@ rtl/core/bvis_pkg.sv @@
// Shared constants, types and state codes of the box volume insertion sort.
package bvis_pkg;

	// Store capacity and box dimension width.
	localparam int MAX_BOXES = 64;
	localparam int DIM_BITS = 20;

	// Derived widths and the output number width.
	localparam int PROD_BITS = 2 * DIM_BITS;
	localparam int VOL_BITS = 3 * DIM_BITS;
	localparam int ADDR_BITS = $clog2(MAX_BOXES);
	localparam int CNT_BITS = $clog2(MAX_BOXES + 1);
	localparam int NUM_OUT_BITS = 6;

	// Depth of the queue between the front and back parts.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

	typedef logic [DIM_BITS-1:0] dim_t;
	typedef logic [PROD_BITS-1:0] prod_t;
	typedef logic [VOL_BITS-1:0] vol_t;
	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [CNT_BITS-1:0] cnt_t;
	typedef logic [NUM_OUT_BITS-1:0] num_out_t;
	typedef logic [QPTR_BITS-1:0] qptr_t;
	typedef logic [QCNT_BITS-1:0] qcnt_t;

	// One classified box as handed from the front part to the back part.
	typedef struct packed {
		vol_t volume;
		logic last;
	} item_t;

	// One entry of the sorted store.
	typedef struct packed {
		vol_t volume;
		addr_t number;
	} entry_t;

	localparam int ENTRY_BITS = $bits(entry_t);

	// Sequencer states of the back part.
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SHIFT = 5'b00010,
		ST_PLACE = 5'b00100,
		ST_EMIT  = 5'b01000,
		ST_LOAD  = 5'b10000
	} state_t;

endpackage

@@ rtl/core/bvis_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module bvis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/bvis_front.sv @@
// Front part: accepts boxes and computes each volume in two multiply stages.
module bvis_front (
	input  logic              clk,
	input  logic              arst_n,
	input  bvis_pkg::dim_t    length_x,
	input  bvis_pkg::dim_t    length_y,
	input  bvis_pkg::dim_t    length_z,
	input  logic              last_box,
	input  logic              box_valid,
	output logic              box_stall,
	output logic              item_valid,
	output bvis_pkg::item_t   item,
	input  logic              item_ready
);

	logic              v_s1;
	bvis_pkg::prod_t   xy_s1;
	bvis_pkg::dim_t    z_s1;
	logic              last_s1;

	logic              v_s2;
	bvis_pkg::prod_t   plo_s2;
	bvis_pkg::prod_t   phi_s2;
	logic              last_s2;

	logic              ready_s1;
	logic              ready_s2;
	logic              take_in;

	// Each stage moves on when it is empty or its successor takes its contents.
	assign ready_s2 = !v_s2 || item_ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign box_stall = !ready_s1;
	assign take_in = box_valid && ready_s1;

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= box_valid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// First stage forms x*y; the second multiplies it by z in two halves.
	always_ff @(posedge clk) begin
		if (take_in) begin
			xy_s1 <= bvis_pkg::prod_t'(length_x) * bvis_pkg::prod_t'(length_y);
			z_s1 <= length_z;
			last_s1 <= last_box;
		end
		if (ready_s2 && v_s1) begin
			plo_s2 <= bvis_pkg::prod_t'(xy_s1[bvis_pkg::DIM_BITS-1:0])
				* bvis_pkg::prod_t'(z_s1);
			phi_s2 <= bvis_pkg::prod_t'(xy_s1[bvis_pkg::PROD_BITS-1:bvis_pkg::DIM_BITS])
				* bvis_pkg::prod_t'(z_s1);
			last_s2 <= last_s1;
		end
	end

	// Combine the partial products into the full volume.
	assign item_valid = v_s2;
	assign item.volume = {phi_s2, bvis_pkg::dim_t'(0)} + bvis_pkg::vol_t'(plo_s2);
	assign item.last = last_s2;

endmodule

@@ rtl/core/bvis_queue.sv @@
// Short queue that decouples the front part from the back part.
module bvis_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  bvis_pkg::item_t   push_item,
	output logic              push_ready,
	output logic              pop_valid,
	output bvis_pkg::item_t   pop_item,
	input  logic              pop_ready
);

	bvis_pkg::item_t   mem_q [bvis_pkg::QUEUE_DEPTH];
	bvis_pkg::qptr_t   wr_ptr_q;
	bvis_pkg::qptr_t   rd_ptr_q;
	bvis_pkg::qcnt_t   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = cnt_q != bvis_pkg::qcnt_t'(bvis_pkg::QUEUE_DEPTH);
	assign pop_valid = cnt_q != bvis_pkg::qcnt_t'(0);
	assign pop_item = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == bvis_pkg::qptr_t'(bvis_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + bvis_pkg::qptr_t'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == bvis_pkg::qptr_t'(bvis_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + bvis_pkg::qptr_t'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + bvis_pkg::qcnt_t'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - bvis_pkg::qcnt_t'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ rtl/core/bvis_back.sv @@
// Back part: inserts volumes into the sorted store and streams out each sorted run.
module bvis_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  bvis_pkg::item_t   item,
	output logic              item_ready,
	output logic              result_valid,
	input  logic              result_stall,
	output bvis_pkg::num_out_t box_number,
	output logic              final_entry,
	output logic              dropped
);

	bvis_pkg::state_t    state_q;
	bvis_pkg::vol_t      vol_q;
	logic                last_q;
	bvis_pkg::addr_t     pos_q;
	bvis_pkg::addr_t     k_q;
	bvis_pkg::cnt_t      count_q;
	logic                overflow_q;
	logic                result_valid_q;
	bvis_pkg::num_out_t  box_number_q;
	logic                final_q;
	logic                dropped_q;

	logic                take;
	logic                full;
	logic                out_free;
	logic                move_up;
	logic                is_final;

	logic                ram_we;
	bvis_pkg::addr_t     ram_waddr;
	bvis_pkg::entry_t    ram_wdata;
	logic                ram_re;
	bvis_pkg::addr_t     ram_raddr;
	logic [bvis_pkg::ENTRY_BITS-1:0] ram_rdata_raw;
	bvis_pkg::entry_t    ram_rdata;
	bvis_pkg::entry_t    new_entry;

	bvis_ram #(
		.WIDTH(bvis_pkg::ENTRY_BITS),
		.DEPTH(bvis_pkg::MAX_BOXES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata_raw)
	);

	assign ram_rdata = ram_rdata_raw;
	assign item_ready = state_q == bvis_pkg::ST_IDLE;
	assign take = item_valid && item_ready;
	assign full = count_q == bvis_pkg::cnt_t'(bvis_pkg::MAX_BOXES);
	assign out_free = !result_valid_q || !result_stall;
	assign move_up = vol_q < ram_rdata.volume;
	assign is_final = (bvis_pkg::cnt_t'(k_q) + bvis_pkg::cnt_t'(1)) == count_q;
	assign new_entry.volume = vol_q;
	assign new_entry.number = count_q[bvis_pkg::ADDR_BITS-1:0];

	// Store port control: the shift reads one entry below while it writes one above.
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = new_entry;
		ram_re = 1'b0;
		ram_raddr = pos_q - bvis_pkg::addr_t'(1);
		unique case (state_q)
			bvis_pkg::ST_IDLE: begin
				ram_raddr = bvis_pkg::addr_t'(count_q - bvis_pkg::cnt_t'(1));
				ram_re = take && !full && (count_q != bvis_pkg::cnt_t'(0));
			end
			bvis_pkg::ST_SHIFT: begin
				ram_we = 1'b1;
				ram_raddr = pos_q - bvis_pkg::addr_t'(2);
				if (move_up) begin
					ram_wdata = ram_rdata;
					ram_re = pos_q != bvis_pkg::addr_t'(1);
				end
			end
			bvis_pkg::ST_PLACE: begin
				ram_we = 1'b1;
			end
			bvis_pkg::ST_EMIT: begin
				ram_raddr = k_q;
				ram_re = out_free;
			end
			bvis_pkg::ST_LOAD: begin
				ram_re = 1'b0;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	// Sequencer, counters and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bvis_pkg::ST_IDLE;
			pos_q <= '0;
			k_q <= '0;
			count_q <= '0;
			overflow_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				bvis_pkg::ST_IDLE: begin
					k_q <= '0;
					if (take) begin
						if (full) begin
							overflow_q <= 1'b1;
							state_q <= item.last ? bvis_pkg::ST_EMIT : bvis_pkg::ST_IDLE;
						end else if (count_q == bvis_pkg::cnt_t'(0)) begin
							pos_q <= '0;
							state_q <= bvis_pkg::ST_PLACE;
						end else begin
							pos_q <= count_q[bvis_pkg::ADDR_BITS-1:0];
							state_q <= bvis_pkg::ST_SHIFT;
						end
					end
				end
				bvis_pkg::ST_SHIFT: begin
					if (move_up) begin
						pos_q <= pos_q - bvis_pkg::addr_t'(1);
						if (pos_q == bvis_pkg::addr_t'(1)) begin
							state_q <= bvis_pkg::ST_PLACE;
						end
					end else begin
						count_q <= count_q + bvis_pkg::cnt_t'(1);
						state_q <= last_q ? bvis_pkg::ST_EMIT : bvis_pkg::ST_IDLE;
					end
				end
				bvis_pkg::ST_PLACE: begin
					count_q <= count_q + bvis_pkg::cnt_t'(1);
					state_q <= last_q ? bvis_pkg::ST_EMIT : bvis_pkg::ST_IDLE;
				end
				bvis_pkg::ST_EMIT: begin
					if (out_free) begin
						state_q <= bvis_pkg::ST_LOAD;
					end
				end
				bvis_pkg::ST_LOAD: begin
					result_valid_q <= 1'b1;
					if (is_final) begin
						count_q <= '0;
						overflow_q <= 1'b0;
						state_q <= bvis_pkg::ST_IDLE;
					end else begin
						k_q <= k_q + bvis_pkg::addr_t'(1);
						state_q <= bvis_pkg::ST_EMIT;
					end
				end
				default: begin
					state_q <= bvis_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Box payload and result payload.
	always_ff @(posedge clk) begin
		if (take) begin
			vol_q <= item.volume;
			last_q <= item.last;
		end
		if (state_q == bvis_pkg::ST_LOAD) begin
			box_number_q <= bvis_pkg::num_out_t'(ram_rdata.number);
			final_q <= is_final;
			dropped_q <= overflow_q;
		end
	end

	assign result_valid = result_valid_q;
	assign box_number = box_number_q;
	assign final_entry = final_q;
	assign dropped = dropped_q;

endmodule

@@ rtl/core/box_volume_insertion_sort_top.sv @@
// Top level of the box volume insertion sort.
//
// Boxes enter on the box channel (box_valid, box_stall) as three dimensions and a
// last_box mark; a transfer happens at an edge with box_valid high and box_stall low.
// Sorted arrival numbers leave on the result channel (result_valid, result_stall)
// with final_entry on the last one of a run and dropped set when the run overflowed.
// Results appear only after a box marked last; the store then empties for the next set.
// The front computes each volume in two multiply stages and hands it through a
// two-entry queue to the back, so the front keeps taking boxes while the back works.
// The back inserts a box by moving each stored entry with a larger volume (up to 63)
// one place up, one store entry per cycle over the single write port of the store
// RAM, and then writing the box into the gap. Each result is then read out of the
// store through an emit state and a load state; a box dropped on a full store and
// marked last goes straight to the readout.
// A stalled result holds in the output register and the
// readout waits; boxes keep flowing into the queue until it fills.
// Reset clears the stage flags, the queue, the box count and the overflow flag; the
// store contents need no clearing since only entries below the count are read.
module box_volume_insertion_sort_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               box_valid,
	output logic               box_stall,
	input  bvis_pkg::dim_t     length_x,
	input  bvis_pkg::dim_t     length_y,
	input  bvis_pkg::dim_t     length_z,
	input  logic               last_box,
	output logic               result_valid,
	input  logic               result_stall,
	output bvis_pkg::num_out_t box_number,
	output logic               final_entry,
	output logic               dropped
);

	logic              f_valid;
	bvis_pkg::item_t   f_item;
	logic              f_ready;
	logic              q_valid;
	bvis_pkg::item_t   q_item;
	logic              q_ready;

	bvis_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.length_x   (length_x),
		.length_y   (length_y),
		.length_z   (length_z),
		.last_box   (last_box),
		.box_valid  (box_valid),
		.box_stall  (box_stall),
		.item_valid (f_valid),
		.item       (f_item),
		.item_ready (f_ready)
	);

	bvis_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_item  (f_item),
		.push_ready (f_ready),
		.pop_valid  (q_valid),
		.pop_item   (q_item),
		.pop_ready  (q_ready)
	);

	bvis_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (q_valid),
		.item         (q_item),
		.item_ready   (q_ready),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.box_number   (box_number),
		.final_entry  (final_entry),
		.dropped      (dropped)
	);

endmodule

@@ rtl/core/bvis_checker.sv @@
// Port-level checks of the box volume insertion sort and their binding to the top level.
module bvis_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               box_valid,
	input  logic               box_stall,
	input  bvis_pkg::dim_t     length_x,
	input  bvis_pkg::dim_t     length_y,
	input  bvis_pkg::dim_t     length_z,
	input  logic               last_box,
	input  logic               result_valid,
	input  logic               result_stall,
	input  bvis_pkg::num_out_t box_number,
	input  logic               final_entry,
	input  logic               dropped
);

	// A stalled result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(box_number) && $stable(final_entry)
			&& $stable(dropped))
		else $error("result payload changed while stalled");

	// Taking the final result of a run drops the result valid; no result follows it directly.
	a_gap_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && final_entry |=> !result_valid)
		else $error("result offered right after the end of a run");

	// The dropped flag is the same on back-to-back results of one run.
	a_dropped_steady: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && $past(result_valid && !result_stall && !final_entry)
			|-> dropped == $past(dropped))
		else $error("dropped flag changed within a run");

	// A stalled box stays offered with the same payload.
	a_box_hold: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && box_stall |=> box_valid && $stable(length_x) && $stable(length_y)
			&& $stable(length_z) && $stable(last_box))
		else $error("box withdrawn or changed while stalled");

endmodule

bind box_volume_insertion_sort_top bvis_checker u_bvis_checker (.*);

@@ bench/tb_box_volume_insertion_sort_top.sv @@
// Self-checking testbench for the box volume insertion sort top level.
`timescale 1ns / 1ps

module tb_box_volume_insertion_sort_top;

	// Long receiver hold-off, the quiet-cycle watchdog limit and the settle time at the end.
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 5000;
	localparam int END_SETTLE = 100;
	localparam int REPORT_MAX = 10;

	// One sorted result as it should appear on the result channel.
	typedef struct packed {
		bvis_pkg::num_out_t number;
		logic               final_mark;
		logic               drop_mark;
	} sorted_result_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               box_valid;
	logic               box_stall;
	bvis_pkg::dim_t     length_x;
	bvis_pkg::dim_t     length_y;
	bvis_pkg::dim_t     length_z;
	logic               last_box;
	logic               result_valid;
	logic               result_stall = 1'b0;
	bvis_pkg::num_out_t box_number;
	logic               final_entry;
	logic               dropped;

	// Predicted contents of the sorted store for the set in progress.
	bvis_pkg::vol_t     held_volume [bvis_pkg::MAX_BOXES];
	bvis_pkg::num_out_t held_number [bvis_pkg::MAX_BOXES];
	int                 held_count = 0;
	logic               held_overflow = 1'b0;

	// Sorted results still owed by the block, oldest first.
	sorted_result_t sorted_due[$];

	int   mismatch_count = 0;
	int   quiet_cycles = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	bit   hold_go = 1'b0;
	int   hold_left = 0;

	box_volume_insertion_sort_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.box_valid    (box_valid),
		.box_stall    (box_stall),
		.length_x     (length_x),
		.length_y     (length_y),
		.length_z     (length_z),
		.last_box     (last_box),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.box_number   (box_number),
		.final_entry  (final_entry),
		.dropped      (dropped)
	);

	// The clock runs at a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Insert one box into the predicted store and, on the last box, queue the sorted run.
	function automatic void sort_box_volume(input bvis_pkg::dim_t x, input bvis_pkg::dim_t y,
			input bvis_pkg::dim_t z, input logic last);
		bvis_pkg::vol_t vol;
		int             pos;
		sorted_result_t res;
		vol = bvis_pkg::vol_t'(x) * bvis_pkg::vol_t'(y) * bvis_pkg::vol_t'(z);
		if (held_count < bvis_pkg::MAX_BOXES) begin
			// Equal volumes stay behind earlier arrivals, so only strictly larger ones move.
			pos = held_count;
			while (pos > 0 && vol < held_volume[pos-1]) begin
				held_volume[pos] = held_volume[pos-1];
				held_number[pos] = held_number[pos-1];
				pos--;
			end
			held_volume[pos] = vol;
			held_number[pos] = bvis_pkg::num_out_t'(held_count);
			held_count++;
		end else begin
			held_overflow = 1'b1;
		end
		if (last) begin
			for (int k = 0; k < held_count; k++) begin
				res.number = held_number[k];
				res.final_mark = (k == held_count - 1);
				res.drop_mark = held_overflow;
				sorted_due.push_back(res);
			end
			held_count = 0;
			held_overflow = 1'b0;
		end
	endfunction

	// Count a failure and describe it while the report budget lasts.
	function automatic void report_mismatch(input string what, input sorted_result_t want,
			input sorted_result_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("%0t: %s: exp num=%0d fin=%0b drop=%0b, got num=%0d fin=%0b drop=%0b",
				$realtime, what, want.number, want.final_mark, want.drop_mark,
				got.number, got.final_mark, got.drop_mark);
	endfunction

	// A dimension is full range most of the time, tiny for ties, or an extreme.
	function automatic bvis_pkg::dim_t pick_dim();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return bvis_pkg::dim_t'($urandom);
		else if (roll < 90)
			return bvis_pkg::dim_t'($urandom_range(3));
		else if (roll < 95)
			return '0;
		else
			return '1;
	endfunction

	// Most sets are short, some medium, and a few fill the store or run past it.
	function automatic int pick_set_size();
		int roll;
		roll = $urandom_range(99);
		if (roll < 85)
			return $urandom_range(1, 12);
		else if (roll < 95)
			return $urandom_range(13, 40);
		else
			return $urandom_range(bvis_pkg::MAX_BOXES, bvis_pkg::MAX_BOXES + 3);
	endfunction

	// Offer one box after a random gap and hold it until the transfer happens.
	task automatic send_box(input bvis_pkg::dim_t x, input bvis_pkg::dim_t y,
			input bvis_pkg::dim_t z, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			box_valid <= 1'b0;
			@(negedge clk);
		end
		box_valid <= 1'b1;
		length_x <= x;
		length_y <= y;
		length_z <= z;
		last_box <= last;
		@(posedge clk);
		while (box_stall !== 1'b0)
			@(posedge clk);
		sort_box_volume(x, y, z, last);
		@(negedge clk);
	endtask

	// Stop offering boxes until every owed result has been taken.
	task automatic wait_results_drained();
		box_valid <= 1'b0;
		@(negedge clk);
		while (sorted_due.size() != 0)
			@(negedge clk);
	endtask

	// Extreme dimensions, ties, a one-box set and a fully reversed set.
	task automatic test_directed_extremes();
		send_box('0, '0, '0, 1'b1);
		send_box('1, '1, '1, 1'b0);
		send_box('0, '1, 20'd5, 1'b0);
		send_box(20'd1, 20'd1, 20'd1, 1'b0);
		send_box('1, 20'd1, 20'd1, 1'b0);
		send_box(20'd1, '1, 20'd1, 1'b0);
		send_box(20'd1, 20'd1, '1, 1'b0);
		send_box(20'h55555, 20'hAAAAA, 20'd1, 1'b0);
		send_box(20'hAAAAA, 20'h55555, 20'd1, 1'b0);
		send_box('0, '0, '0, 1'b1);
		for (int k = 5; k >= 1; k--)
			send_box(bvis_pkg::dim_t'(k), 20'd1, 20'd1, k == 1);
		wait_results_drained();
	endtask

	// Fill the store exactly, then overflow it so the last boxes are dropped.
	task automatic test_store_full();
		for (int k = 0; k < bvis_pkg::MAX_BOXES; k++)
			send_box(pick_dim(), pick_dim(), pick_dim(), k == bvis_pkg::MAX_BOXES - 1);
		for (int k = 0; k < bvis_pkg::MAX_BOXES + 3; k++)
			send_box(pick_dim(), pick_dim(), pick_dim(), k == bvis_pkg::MAX_BOXES + 2);
		// The following set must come out clean again.
		send_box(20'd3, 20'd3, 20'd3, 1'b0);
		send_box(20'd2, 20'd2, 20'd2, 1'b1);
		wait_results_drained();
	endtask

	// Hold the result channel off while two sets arrive, so the input backs up.
	task automatic test_output_backpressure();
		hold_go = 1'b1;
		for (int k = 0; k < 6; k++)
			send_box(pick_dim(), pick_dim(), pick_dim(), k == 5);
		for (int k = 0; k < 10; k++)
			send_box(pick_dim(), pick_dim(), pick_dim(), k == 9);
		wait_results_drained();
	endtask

	// Whole sets of random boxes, each closed by a box marked last.
	task automatic test_random_sets(input int box_total);
		int sent;
		int size;
		sent = 0;
		while (sent < box_total) begin
			size = pick_set_size();
			for (int k = 0; k < size; k++)
				send_box(pick_dim(), pick_dim(), pick_dim(), k == size - 1);
			sent += size;
		end
		wait_results_drained();
	endtask

	// The receiver stalls at random, or for a long counted stretch when asked.
	always @(negedge clk) begin
		if (hold_go) begin
			hold_left = HOLD_CYCLES;
			hold_go = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Each result transfer is checked against the oldest owed result.
	always @(posedge clk) begin : check_results
		sorted_result_t want;
		sorted_result_t got;
		if (arst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0) begin
			got.number = box_number;
			got.final_mark = final_entry;
			got.drop_mark = dropped;
			if (sorted_due.size() == 0) begin
				want = '0;
				report_mismatch("result with none owed", want, got);
			end else begin
				want = sorted_due.pop_front();
				if (got.number !== want.number || got.final_mark !== want.final_mark ||
						got.drop_mark !== want.drop_mark)
					report_mismatch("result mismatch", want, got);
			end
		end
	end

	// The run ends if nothing moves on either channel for too long.
	always @(posedge clk) begin
		if ((box_valid === 1'b1 && box_stall === 1'b0) ||
				(result_valid === 1'b1 && result_stall === 1'b0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Reset, then the tests in turn, with random sets under each of the three idling mixes.
	initial begin
		arst_n = 1'b0;
		box_valid = 1'b0;
		length_x = '0;
		length_y = '0;
		length_z = '0;
		last_box = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 36;
		recv_idle_pct = 59;
		test_directed_extremes();
		test_store_full();
		test_output_backpressure();
		test_random_sets(105);

		send_idle_pct = 59;
		recv_idle_pct = 36;
		test_random_sets(105);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_sets(105);

		repeat (END_SETTLE) @(posedge clk);
		if (mismatch_count == 0 && sorted_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/bvis_pkg.sv
rtl/core/bvis_ram.sv
rtl/core/bvis_front.sv
rtl/core/bvis_queue.sv
rtl/core/bvis_back.sv
rtl/core/box_volume_insertion_sort_top.sv
rtl/core/bvis_checker.sv
bench/tb_box_volume_insertion_sort_top.sv
